// ----- rtl/core/rbd_pkg.sv -----
// Shared types and constants for the RGBA box downscaler.
// No dependencies; every other file in rtl/core refers to this package.
`timescale 1ns / 1ps

package rbd_pkg;

    // Size limits
    localparam int MAX_TARGET_DIM = 2048;
    localparam int MAX_SOURCE_DIM = 4096;

    // Derived widths
    localparam int TGT_AW  = $clog2(MAX_TARGET_DIM);     // destination index
    localparam int TGT_W   = TGT_AW + 1;                 // destination size
    localparam int SRC_W   = $clog2(MAX_SOURCE_DIM) + 1; // source size
    localparam int SRC_CW  = SRC_W - 1;                  // source position
    localparam int GEO_DW  = TGT_W + SRC_W - 1;          // boundary dividend
    localparam int GEO_CW  = $clog2(SRC_W);              // boundary step count

    // Channel and accumulator widths
    localparam int NUM_CH  = 4;
    localparam int CH_W    = 8;
    localparam int SUM_W   = 32;
    localparam int CNT_W   = 25;
    localparam int MEAN_CW = $clog2(CH_W);

    // Configuration port
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = SRC_W;

    localparam logic [CFG_IW-1:0] CFG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_TARGET_WIDTH  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_TARGET_HEIGHT = 3'd3;

    typedef struct packed {
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
        logic [CH_W-1:0] in_alpha;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0]   out_red;
        logic [CH_W-1:0]   out_green;
        logic [CH_W-1:0]   out_blue;
        logic [CH_W-1:0]   out_alpha;
        logic [TGT_AW-1:0] out_column;
        logic [TGT_AW-1:0] out_row;
        logic              frame_done;
    } t_pix_out;

    // Controller to datapath
    typedef struct packed {
        logic restart;
        logic geo_init_col;
        logic geo_init_row;
        logic geo_step;
        logic take;
        logic acc;
        logic mean_step;
        logic out_load;
        logic adv;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic cfg_hit;
        logic emit;
        logic geo_need;
        logic geo_last;
        logic mean_last;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/core/rgba_box_downscaler.sv -----
// RGBA box (area-average) downscaler, top level.
// Depends on rbd_pkg, rbd_ctrl and rbd_datapath.
//
// Source pixels arrive in raster order on the input request channel; each
// destination pixel is the truncated per-channel mean of its source block,
// given on the output request channel when the last source pixel of that
// block has been taken. A pixel that closes no block is taken, accumulated
// and advanced; when it is the last of a destination column or band, the
// next boundary comes from a 13-step shared divider. A pixel that closes
// a block also runs the 8-step mean divider and the output load, and
// waits while a previous result is still stalled. Any write to a size
// register restarts the frame and holds the input off while both first
// boundaries are worked out. The per-column sums live in one 2048-entry
// memory with a single read and a single write port; entries are rewritten
// by the first pixel of each block, so no clearing pass is needed.
`timescale 1ns / 1ps

module rgba_box_downscaler (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  rbd_pkg::t_pix_in           i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output rbd_pkg::t_pix_out          o_out_data,
    input  logic                       i_cfg_we,
    input  logic [rbd_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [rbd_pkg::CFG_DW-1:0] i_cfg_wdata
);

    rbd_pkg::t_cmd    cmd;
    rbd_pkg::t_status status;

    // Sequencer
    rbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Accumulation, division and output
    rbd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

// ----- rtl/core/rbd_ctrl.sv -----
// Sequencing state machine for the RGBA box downscaler.
// Depends on rbd_pkg for the command and status structs.
`timescale 1ns / 1ps

module rbd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  rbd_pkg::t_status i_status,
    output rbd_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_INIT_COL,
        S_GEO_INIT,
        S_INIT_ROW,
        S_IDLE,
        S_ACC,
        S_MEAN,
        S_OUT,
        S_ADV,
        S_GEO
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT_COL: begin
                o_cmd.restart      = 1'b1;
                o_cmd.geo_init_col = 1'b1;
                n_state            = S_GEO_INIT;
            end
            S_GEO_INIT: begin
                o_cmd.geo_step = 1'b1;
                if (i_status.geo_last) n_state = S_INIT_ROW;
            end
            S_INIT_ROW: begin
                o_cmd.geo_init_row = 1'b1;
                n_state            = S_GEO;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_status.emit ? S_MEAN : S_ADV;
            end
            S_MEAN: begin
                o_cmd.mean_step = 1'b1;
                if (i_status.mean_last) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_ADV;
                end
            end
            S_ADV: begin
                o_cmd.adv = 1'b1;
                n_state   = i_status.geo_need ? S_GEO : S_IDLE;
            end
            S_GEO: begin
                o_cmd.geo_step = 1'b1;
                if (i_status.geo_last) n_state = S_IDLE;
            end
            default: n_state = S_INIT_COL;
        endcase
        // a register write restarts the frame
        if (i_status.cfg_hit) n_state = S_INIT_COL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT_COL;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/rbd_datapath.sv -----
// Datapath of the RGBA box downscaler: config, raster counters, column
// accumulator memory, mean divider, boundary divider and output register.
// Depends on rbd_pkg.
`timescale 1ns / 1ps

module rbd_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rbd_pkg::t_pix_in              i_in_data,
    output rbd_pkg::t_pix_out             o_out_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic                          i_cfg_we,
    input  logic [rbd_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [rbd_pkg::CFG_DW-1:0]    i_cfg_wdata,
    input  rbd_pkg::t_cmd                 i_cmd,
    output rbd_pkg::t_status              o_status
);

    localparam int SRC_W  = rbd_pkg::SRC_W;
    localparam int SRC_CW = rbd_pkg::SRC_CW;
    localparam int TGT_W  = rbd_pkg::TGT_W;
    localparam int TGT_AW = rbd_pkg::TGT_AW;
    localparam int GEO_DW = rbd_pkg::GEO_DW;
    localparam int GEO_CW = rbd_pkg::GEO_CW;
    localparam int SUM_W  = rbd_pkg::SUM_W;
    localparam int CNT_W  = rbd_pkg::CNT_W;
    localparam int CH_W   = rbd_pkg::CH_W;
    localparam int NUM_CH = rbd_pkg::NUM_CH;
    localparam int MCW    = rbd_pkg::MEAN_CW;

    typedef struct packed {
        logic [NUM_CH-1:0][SUM_W-1:0] sum;
        logic [CNT_W-1:0]             cnt;
    } t_acc_entry;

    typedef enum logic [1:0] {
        G_COL_FIRST,
        G_ROW_FIRST,
        G_COL,
        G_ROW
    } t_geo_sel;

    // ---------------------------------------------------------------
    // Configuration registers and effective sizes
    logic [SRC_W-1:0] r_src_w, r_src_h;
    logic [TGT_W-1:0] r_tgt_w, r_tgt_h;
    logic             cfg_hit;

    assign cfg_hit = i_cfg_we && (i_cfg_index == rbd_pkg::CFG_SOURCE_WIDTH ||
                                  i_cfg_index == rbd_pkg::CFG_SOURCE_HEIGHT ||
                                  i_cfg_index == rbd_pkg::CFG_TARGET_WIDTH ||
                                  i_cfg_index == rbd_pkg::CFG_TARGET_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SRC_W'(1);
            r_src_h <= SRC_W'(1);
            r_tgt_w <= TGT_W'(1);
            r_tgt_h <= TGT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rbd_pkg::CFG_SOURCE_WIDTH:  r_src_w <= i_cfg_wdata;
                rbd_pkg::CFG_SOURCE_HEIGHT: r_src_h <= i_cfg_wdata;
                rbd_pkg::CFG_TARGET_WIDTH:  r_tgt_w <= i_cfg_wdata[TGT_W-1:0];
                rbd_pkg::CFG_TARGET_HEIGHT: r_tgt_h <= i_cfg_wdata[TGT_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic [SRC_W-1:0] eff_src(input logic [SRC_W-1:0] v);
        logic [SRC_W-1:0] r;
        r = v;
        if (v == '0) r = SRC_W'(1);
        else if (v > SRC_W'(rbd_pkg::MAX_SOURCE_DIM)) r = SRC_W'(rbd_pkg::MAX_SOURCE_DIM);
        return r;
    endfunction

    function automatic logic [TGT_W-1:0] eff_dst(input logic [TGT_W-1:0] v,
                                                 input logic [SRC_W-1:0] s);
        logic [TGT_W-1:0] r;
        r = v;
        if (v == '0) r = TGT_W'(1);
        else if (v > TGT_W'(rbd_pkg::MAX_TARGET_DIM)) r = TGT_W'(rbd_pkg::MAX_TARGET_DIM);
        if ({1'b0, r} > s) r = s[TGT_W-1:0];
        return r;
    endfunction

    logic [SRC_W-1:0] sw, sh;
    logic [TGT_W-1:0] dw, dh;

    assign sw = eff_src(r_src_w);
    assign sh = eff_src(r_src_h);
    assign dw = eff_dst(r_tgt_w, sw);
    assign dh = eff_dst(r_tgt_h, sh);

    // ---------------------------------------------------------------
    // Raster position and block boundaries
    logic [SRC_CW-1:0] r_sc, r_sr;
    logic [TGT_AW-1:0] r_tc, r_tr;
    logic [SRC_W-1:0]  r_cbnd, r_rbnd, r_cbnd0, r_rbnd0, r_cstart;
    logic              r_band_first;
    logic [SRC_W-1:0]  sc_inc, sr_inc;
    logic              col_end, row_end, line_end, last_row, fresh;
    logic              col_div, row_div;

    assign sc_inc   = {1'b0, r_sc} + SRC_W'(1);
    assign sr_inc   = {1'b0, r_sr} + SRC_W'(1);
    assign col_end  = sc_inc >= r_cbnd;
    assign row_end  = sr_inc >= r_rbnd;
    assign line_end = sc_inc >= sw;
    assign last_row = sr_inc >= sh;
    assign fresh    = r_band_first && ({1'b0, r_sc} == r_cstart);
    assign col_div  = !line_end && col_end;
    assign row_div  = line_end && !last_row && row_end;

    // ---------------------------------------------------------------
    // Boundary divider: (k * s) / d, one quotient bit per cycle
    logic [GEO_DW-1:0] r_grem, r_gdiv;
    logic [SRC_W-1:0]  r_gq, n_gq;
    logic [GEO_CW-1:0] r_gcnt;
    t_geo_sel          r_gsel;
    logic              geo_load, geo_bit;
    t_geo_sel          geo_sel;
    logic [TGT_W-1:0]  geo_k, geo_d;
    logic [SRC_W-1:0]  geo_s;
    logic [TGT_W+SRC_W-1:0] geo_prod;

    assign geo_load = i_cmd.geo_init_col || i_cmd.geo_init_row ||
                      (i_cmd.adv && (col_div || row_div));

    always_comb begin
        geo_sel = G_COL;
        geo_k   = TGT_W'(1);
        geo_s   = sw;
        geo_d   = dw;
        if (i_cmd.geo_init_col) begin
            geo_sel = G_COL_FIRST;
        end else if (i_cmd.geo_init_row) begin
            geo_sel = G_ROW_FIRST;
            geo_s   = sh;
            geo_d   = dh;
        end else if (row_div) begin
            geo_sel = G_ROW;
            geo_k   = {1'b0, r_tr} + TGT_W'(2);
            geo_s   = sh;
            geo_d   = dh;
        end else begin
            geo_k   = {1'b0, r_tc} + TGT_W'(2);
        end
    end

    assign geo_prod = geo_k * geo_s;
    assign geo_bit  = r_grem >= r_gdiv;
    assign n_gq     = {r_gq[SRC_W-2:0], geo_bit};

    always_ff @(posedge i_clk) begin
        if (geo_load) begin
            r_grem <= geo_prod[GEO_DW-1:0];
            r_gdiv <= {geo_d, (SRC_W-1)'(0)};
            r_gq   <= '0;
            r_gcnt <= GEO_CW'(SRC_W - 1);
            r_gsel <= geo_sel;
        end else if (i_cmd.geo_step) begin
            if (geo_bit) r_grem <= r_grem - r_gdiv;
            r_gdiv <= r_gdiv >> 1;
            r_gq   <= n_gq;
            r_gcnt <= r_gcnt - GEO_CW'(1);
        end
    end

    // ---------------------------------------------------------------
    // Position counters and boundary updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc         <= '0;
            r_sr         <= '0;
            r_tc         <= '0;
            r_tr         <= '0;
            r_cstart     <= '0;
            r_band_first <= 1'b1;
            r_cbnd       <= SRC_W'(1);
            r_rbnd       <= SRC_W'(1);
            r_cbnd0      <= SRC_W'(1);
            r_rbnd0      <= SRC_W'(1);
        end else begin
            if (i_cmd.restart) begin
                r_sc         <= '0;
                r_sr         <= '0;
                r_tc         <= '0;
                r_tr         <= '0;
                r_cstart     <= '0;
                r_band_first <= 1'b1;
            end else if (i_cmd.adv) begin
                if (line_end) begin
                    r_sc     <= '0;
                    r_tc     <= '0;
                    r_cstart <= '0;
                    r_cbnd   <= r_cbnd0;
                    if (last_row) begin
                        r_sr         <= '0;
                        r_tr         <= '0;
                        r_rbnd       <= r_rbnd0;
                        r_band_first <= 1'b1;
                    end else begin
                        r_sr         <= sr_inc[SRC_CW-1:0];
                        r_band_first <= row_end;
                        if (row_end) r_tr <= r_tr + TGT_AW'(1);
                    end
                end else begin
                    r_sc <= sc_inc[SRC_CW-1:0];
                    if (col_end) begin
                        r_tc     <= r_tc + TGT_AW'(1);
                        r_cstart <= r_cbnd;
                    end
                end
            end
            // boundary divider result on its final step
            if (i_cmd.geo_step && r_gcnt == '0) begin
                case (r_gsel)
                    G_COL_FIRST: begin
                        r_cbnd  <= n_gq;
                        r_cbnd0 <= n_gq;
                    end
                    G_ROW_FIRST: begin
                        r_rbnd  <= n_gq;
                        r_rbnd0 <= n_gq;
                    end
                    G_COL:   r_cbnd <= n_gq;
                    default: r_rbnd <= n_gq;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Column accumulator memory, one entry per destination column
    t_acc_entry r_mem [rbd_pkg::MAX_TARGET_DIM];
    t_acc_entry r_rd, n_entry;
    rbd_pkg::t_pix_in r_px;
    logic [NUM_CH-1:0][CH_W-1:0] px_ch;

    assign px_ch = {r_px.in_red, r_px.in_green, r_px.in_blue, r_px.in_alpha};

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_entry.sum[c] = fresh ? SUM_W'(px_ch[c]) : r_rd.sum[c] + SUM_W'(px_ch[c]);
        end
        n_entry.cnt = fresh ? CNT_W'(1) : r_rd.cnt + CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_rd <= r_mem[r_tc];
            r_px <= i_in_data;
        end
        if (i_cmd.acc) r_mem[r_tc] <= n_entry;
    end

    // ---------------------------------------------------------------
    // Mean divider: four channels share one shifted count, 8 steps
    logic [NUM_CH-1:0][SUM_W-1:0] r_mrem;
    logic [NUM_CH-1:0][CH_W-1:0]  r_mq;
    logic [SUM_W-1:0]             r_mdiv;
    logic [MCW-1:0]               r_mcnt;
    logic [CNT_W-1:0]             mean_d;
    logic [TGT_AW-1:0]            r_ocol, r_orow;
    logic                         r_olast;

    assign mean_d = (n_entry.cnt == '0) ? CNT_W'(1) : n_entry.cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_mrem  <= n_entry.sum;
            r_mdiv  <= {mean_d, (SUM_W-CNT_W)'(0)};
            r_mcnt  <= MCW'(CH_W - 1);
            r_ocol  <= r_tc;
            r_orow  <= r_tr;
            r_olast <= line_end && last_row;
        end else if (i_cmd.mean_step) begin
            for (int c = 0; c < NUM_CH; c++) begin
                if (r_mrem[c] >= r_mdiv) r_mrem[c] <= r_mrem[c] - r_mdiv;
                r_mq[c] <= {r_mq[c][CH_W-2:0], r_mrem[c] >= r_mdiv};
            end
            r_mdiv <= r_mdiv >> 1;
            r_mcnt <= r_mcnt - MCW'(1);
        end
    end

    // ---------------------------------------------------------------
    // Output register
    logic r_ovalid;
    rbd_pkg::t_pix_out r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_odata.out_red    <= r_mq[3];
            r_odata.out_green  <= r_mq[2];
            r_odata.out_blue   <= r_mq[1];
            r_odata.out_alpha  <= r_mq[0];
            r_odata.out_column <= r_ocol;
            r_odata.out_row    <= r_orow;
            r_odata.frame_done <= r_olast;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    // ---------------------------------------------------------------
    // Status
    assign o_status.cfg_hit   = cfg_hit;
    assign o_status.emit      = col_end && row_end;
    assign o_status.geo_need  = col_div || row_div;
    assign o_status.geo_last  = (r_gcnt == '0);
    assign o_status.mean_last = (r_mcnt == '0);
    assign o_status.out_free  = !r_ovalid || i_out_ready;

endmodule

// ----- rtl/core/rbd_checker.sv -----
// Port-level checks for the RGBA box downscaler, bound to the top level.
// Depends on rbd_pkg and rgba_box_downscaler.
`timescale 1ns / 1ps

module rbd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input rbd_pkg::t_pix_out          o_out_data,
    input logic                       i_cfg_we,
    input logic [rbd_pkg::CFG_IW-1:0] i_cfg_index
);

    // stalled result request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result request dropped or changed while stalled");

    // one pixel in flight: a taken request closes the input
    a_in_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input reopened right after a request was taken");

    // a register write restarts the frame and closes the input
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_index == rbd_pkg::CFG_SOURCE_WIDTH ||
                     i_cfg_index == rbd_pkg::CFG_SOURCE_HEIGHT ||
                     i_cfg_index == rbd_pkg::CFG_TARGET_WIDTH ||
                     i_cfg_index == rbd_pkg::CFG_TARGET_HEIGHT) |=> !o_in_ready)
        else $error("input open right after a register write");

    // a new result is only raised while a pixel is still being processed
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_ready)
        else $error("result raised while idle");

endmodule

bind rgba_box_downscaler rbd_checker u_rbd_checker (.*);

// ----- tb/sv/rgba_box_downscaler_tb.sv -----
// Testbench for rgba_box_downscaler: streams RGBA source pixels, predicts each
// averaged destination pixel and checks the results. Depends on rbd_pkg and the RTL.
`timescale 1ns / 1ps

module rgba_box_downscaler_tb;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_ready;
    rbd_pkg::t_pix_in           i_in_data   = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    rbd_pkg::t_pix_out          o_out_data;
    logic                       i_cfg_we    = 1'b0;
    logic [rbd_pkg::CFG_IW-1:0] i_cfg_index = '0;
    logic [rbd_pkg::CFG_DW-1:0] i_cfg_wdata = '0;

    rgba_box_downscaler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Predictor state: registers, raster position and per-column sums
    int unsigned reg_src_w, reg_src_h, reg_tgt_w, reg_tgt_h;
    int unsigned red_acc [rbd_pkg::MAX_TARGET_DIM];
    int unsigned green_acc [rbd_pkg::MAX_TARGET_DIM];
    int unsigned blue_acc [rbd_pkg::MAX_TARGET_DIM];
    int unsigned alpha_acc [rbd_pkg::MAX_TARGET_DIM];
    int unsigned pix_count [rbd_pkg::MAX_TARGET_DIM];
    int unsigned src_col, src_row, dst_col, dst_row, col_bound, row_bound;
    bit          first_band_row;

    rbd_pkg::t_pix_out mean_queue[$];
    int          fail_count     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    // Clock and receiver back-pressure
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int unsigned clamp_src(int unsigned v);
        if (v == 0) return 1;
        return (v > rbd_pkg::MAX_SOURCE_DIM) ? rbd_pkg::MAX_SOURCE_DIM : v;
    endfunction

    function automatic int unsigned clamp_dst(int unsigned v, int unsigned s);
        if (v == 0) v = 1;
        if (v > rbd_pkg::MAX_TARGET_DIM) v = rbd_pkg::MAX_TARGET_DIM;
        return (v > s) ? s : v;
    endfunction

    function automatic void restart_raster();
        int unsigned sw, sh;
        sw = clamp_src(reg_src_w);
        sh = clamp_src(reg_src_h);
        src_col = 0;
        src_row = 0;
        dst_col = 0;
        dst_row = 0;
        col_bound = sw / clamp_dst(reg_tgt_w, sw);
        row_bound = sh / clamp_dst(reg_tgt_h, sh);
        first_band_row = 1'b1;
    endfunction

    // Accumulate one source pixel; returns 1 with the averaged pixel when a block closes
    function automatic bit predict_mean(rbd_pkg::t_pix_in p, output rbd_pkg::t_pix_out r);
        int unsigned sw, sh, dw, dh, tc, n;
        bit fresh, col_end, row_end, last_blk;
        sw = clamp_src(reg_src_w);
        sh = clamp_src(reg_src_h);
        dw = clamp_dst(reg_tgt_w, sw);
        dh = clamp_dst(reg_tgt_h, sh);
        tc = (dst_col >= rbd_pkg::MAX_TARGET_DIM) ? rbd_pkg::MAX_TARGET_DIM - 1 : dst_col;
        fresh = first_band_row && (src_col == (tc * sw) / dw);
        red_acc[tc]   = fresh ? p.in_red   : red_acc[tc]   + p.in_red;
        green_acc[tc] = fresh ? p.in_green : green_acc[tc] + p.in_green;
        blue_acc[tc]  = fresh ? p.in_blue  : blue_acc[tc]  + p.in_blue;
        alpha_acc[tc] = fresh ? p.in_alpha : alpha_acc[tc] + p.in_alpha;
        n = fresh ? 1 : ((pix_count[tc] + 1) & 32'h1FF_FFFF);
        pix_count[tc] = n;
        col_end  = (src_col + 1) >= col_bound;
        row_end  = (src_row + 1) >= row_bound;
        last_blk = (src_col + 1 >= sw) && (src_row + 1 >= sh);
        r = '0;
        if (col_end && row_end) begin
            if (n == 0) n = 1;
            r.out_red    = 8'(red_acc[tc] / n);
            r.out_green  = 8'(green_acc[tc] / n);
            r.out_blue   = 8'(blue_acc[tc] / n);
            r.out_alpha  = 8'(alpha_acc[tc] / n);
            r.out_column = 11'(tc);
            r.out_row    = 11'(dst_row);
            r.frame_done = last_blk;
        end
        // step the raster position
        if (src_col + 1 >= sw) begin
            src_col = 0;
            dst_col = 0;
            col_bound = sw / dw;
            if (src_row + 1 >= sh) begin
                restart_raster();
            end else if (row_end) begin
                src_row++;
                dst_row++;
                row_bound = ((dst_row + 1) * sh) / dh;
                first_band_row = 1'b1;
            end else begin
                src_row++;
                first_band_row = 1'b0;
            end
        end else begin
            src_col++;
            if (col_end) begin
                dst_col = tc + 1;
                col_bound = ((dst_col + 1) * sw) / dw;
            end
        end
        return col_end && row_end;
    endfunction

    // Send one source pixel request; called at a rising edge
    task automatic send_pixel(rbd_pkg::t_pix_in p);
        rbd_pkg::t_pix_out r;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        do @(posedge i_clk); while (!o_in_ready);
        if (predict_mean(p, r)) mean_queue.push_back(r);
    endtask

    task automatic send_random(int count);
        repeat (count) send_pixel(rbd_pkg::t_pix_in'($urandom));
    endtask

    // Drop valid, wait for all expected pixels and let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (mean_queue.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [rbd_pkg::CFG_IW-1:0] idx, int unsigned val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= 13'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            rbd_pkg::CFG_SOURCE_WIDTH: begin
                reg_src_w = val & 13'h1FFF;
                restart_raster();
            end
            rbd_pkg::CFG_SOURCE_HEIGHT: begin
                reg_src_h = val & 13'h1FFF;
                restart_raster();
            end
            rbd_pkg::CFG_TARGET_WIDTH: begin
                reg_tgt_w = val & 12'hFFF;
                restart_raster();
            end
            rbd_pkg::CFG_TARGET_HEIGHT: begin
                reg_tgt_h = val & 12'hFFF;
                restart_raster();
            end
            default: ;
        endcase
    endtask

    task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned tw, int unsigned th);
        drain();
        write_reg(rbd_pkg::CFG_SOURCE_WIDTH, sw);
        write_reg(rbd_pkg::CFG_SOURCE_HEIGHT, sh);
        write_reg(rbd_pkg::CFG_TARGET_WIDTH, tw);
        write_reg(rbd_pkg::CFG_TARGET_HEIGHT, th);
    endtask

    // Result checker
    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        rbd_pkg::t_pix_out e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (mean_queue.size() == 0) begin
                $error("unexpected output request: %h", o_out_data);
                fail_count++;
            end else begin
                e = mean_queue.pop_front();
                check_field("out_red",    e.out_red,    o_out_data.out_red);
                check_field("out_green",  e.out_green,  o_out_data.out_green);
                check_field("out_blue",   e.out_blue,   o_out_data.out_blue);
                check_field("out_alpha",  e.out_alpha,  o_out_data.out_alpha);
                check_field("out_column", e.out_column, o_out_data.out_column);
                check_field("out_row",    e.out_row,    o_out_data.out_row);
                check_field("frame_done", e.frame_done, o_out_data.frame_done);
            end
        end
    end

    // Default 1x1 frame: every pixel is its own block, channel extremes
    task automatic test_reset_sizes();
        send_pixel('{8'h00, 8'hFF, 8'h00, 8'hFF});
        send_pixel('{8'hFF, 8'h00, 8'hFF, 8'h00});
        send_pixel('{8'hA5, 8'h5A, 8'h01, 8'h80});
    endtask

    // 2x2 into 1x1, full-scale sums and truncation
    task automatic test_averaging();
        set_sizes(2, 2, 1, 1);
        repeat (4) send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_pixel('{8'd1, 8'd2, 8'd3, 8'd0});
        send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel('{8'd2, 8'd2, 8'd2, 8'd255});
    endtask

    // Zero sizes act as one, oversize targets clamp to source
    task automatic test_clamping();
        set_sizes(0, 0, 0, 0);
        send_random(2);
        set_sizes(3, 2, 4095, 2048);
        send_random(6);
        set_sizes(8191, 1, 4095, 0);
        send_random(5);
    endtask

    // Unlisted index ignored; a rewrite mid-frame restarts the raster
    task automatic test_register_writes();
        set_sizes(3, 3, 2, 2);
        send_random(4);
        write_reg(3'd4, 13'h1FFF);
        write_reg(3'd7, 0);
        send_random(3);
        drain();
        write_reg(rbd_pkg::CFG_TARGET_WIDTH, 3);
        send_random(9);
    endtask

    // Largest sizes: start of a full-width row and of a full-height column
    task automatic test_extreme_frames();
        set_sizes(4096, 1, 2048, 1);
        send_random(128);
        set_sizes(1, 4096, 1, 2048);
        send_random(128);
        set_sizes(4096, 2, 1, 1);
        send_random(64);
    endtask

    // Random small geometries, mostly whole frames with a partial tail
    task automatic test_random_frames(int idle_pct, int stall_pct);
        int unsigned sw, sh;
        int sent;
        int n;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < 100) begin
            sw = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            sh = $urandom_range(10, 1);
            set_sizes(sw, sh, $urandom_range(14), $urandom_range(12));
            n = int'(sw * sh * $urandom_range(2, 1) + $urandom_range(sw));
            send_random(n);
            sent += n;
        end
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        reg_src_w = 1;
        reg_src_h = 1;
        reg_tgt_w = 1;
        reg_tgt_h = 1;
        restart_raster();
        @(posedge i_clk);
        test_reset_sizes();
        test_averaging();
        test_clamping();
        test_register_writes();
        test_extreme_frames();
        test_random_frames(0, 0);
        test_random_frames(61, 0);
        test_random_frames(0, 61);
        test_random_frames(6, 6);
        drain();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
